// ----- rtl/lph_pkg.sv -----
// Package for the linear probe hash table: sizes, command and status codes,
// and the request/response structs between the controller and the slot store.
// No dependencies.
`default_nettype none

package lph_pkg;

  localparam int SLOTS         = 256;
  localparam int IDX_W         = $clog2(SLOTS);
  localparam int COUNT_W       = IDX_W + 1;
  localparam int HASH_W        = 32;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int FILL_W        = 9;
  localparam logic [FILL_W-1:0] FILL_RESET = 9'd204;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [HASH_W-1:0]        wr_hash;
    logic [PAYLOAD_WIDTH-1:0] wr_payload;
    logic                     clear;
  } store_req_t;

  typedef struct packed {
    logic                     valid;
    logic [HASH_W-1:0]        hash;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } store_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/lph_if.sv -----
// Valid/ready channel interfaces for the hash table's command and result words.
// Depends on lph_pkg.
`default_nettype none

interface lph_in_if;
  import lph_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [HASH_W-1:0]        key_hash;
  logic [PAYLOAD_WIDTH-1:0] payload_in;
  modport source (output valid, command, key_hash, payload_in, input ready);
  modport sink   (input valid, command, key_hash, payload_in, output ready);
endinterface

interface lph_out_if;
  import lph_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [IDX_W-1:0]         slot_index;
  logic [PAYLOAD_WIDTH-1:0] payload_out;
  logic [COUNT_W-1:0]       entry_count_out;
  modport source (output valid, status, slot_index, payload_out, entry_count_out,
                  input ready);
  modport sink   (input valid, status, slot_index, payload_out, entry_count_out,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/lph_store.sv -----
// Slot store: valid flags in flops that clear together, hash and payload in a
// synchronous RAM. Read data and the read slot's valid flag are registered and arrive in the next cycle.
// Depends on lph_pkg.
`default_nettype none

module lph_store (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lph_pkg::store_req_t req,
  output lph_pkg::store_rsp_t rsp
);
  import lph_pkg::*;

  logic [HASH_W+PAYLOAD_WIDTH-1:0] mem [SLOTS];
  logic [HASH_W+PAYLOAD_WIDTH-1:0] rd_data_r;
  logic [SLOTS-1:0]                valid_r;
  logic                            rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_hash, req.wr_payload};
    end
    rd_data_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  assign rsp.valid   = rd_valid_r;
  assign rsp.hash    = rd_data_r[HASH_W+PAYLOAD_WIDTH-1:PAYLOAD_WIDTH];
  assign rsp.payload = rd_data_r[PAYLOAD_WIDTH-1:0];

`ifndef ASSERT_OFF
  // an insert only ever lands in an empty slot
  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> !valid_r[req.wr_addr])
    else $error("insert overwrote an occupied slot");
`endif

endmodule

`default_nettype wire

// ----- rtl/linear_probe_hash_table.sv -----
// Linear probe hash table, top level: probe controller, fill limit register,
// entry counter and output register. Depends on lph_pkg, lph_if, lph_store.
//
// Usage:
//   in_ch  (sink)  : command word {command, key_hash, payload_in}; 0 insert,
//                    1 lookup, 2 clear. Accepted on valid && ready.
//   out_ch (source): one result word per command {status, slot_index,
//                    payload_out, entry_count_out}.
//   cfg_we/cfg_wdata: writes fill_limit (reset 204); write only while idle.
//   Timing: a command is taken in the idle cycle, then one slot is probed per
//   cycle from the home slot (key_hash mod 256), one RAM read each, for 1 to
//   256 slots; clear, refused inserts and unused codes end at the first slot.
//   ready is high in the idle cycle, also while an earlier result still waits
//   on out_ch.
//   Reset empties every slot at once, zeroes the count and drops any result.
//   Receiver stall: the result register holds; a finished probe waits in place
//   (re-reading its slot) until the register frees, then writes its result.
`default_nettype none

module linear_probe_hash_table (
  input  wire                        clk,
  input  wire                        rst_n,
  lph_in_if.sink                     in_ch,
  lph_out_if.source                  out_ch,
  input  wire                        cfg_we,
  input  wire [lph_pkg::FILL_W-1:0]  cfg_wdata
);
  import lph_pkg::*;

  typedef enum logic {S_IDLE, S_PROBE} state_t;

  state_t                   state_r;
  logic [1:0]               cmd_r;
  logic [HASH_W-1:0]        hash_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         probe_n_r;
  logic [COUNT_W-1:0]       count_r;
  logic [FILL_W-1:0]        fill_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [IDX_W-1:0]         out_slot_r;
  logic [PAYLOAD_WIDTH-1:0] out_pay_r;

  store_req_t               req;
  store_rsp_t               rsp;

  logic                     accept;
  logic                     out_free;
  logic                     done;
  logic                     fin;
  logic                     full;
  logic                     hit;
  logic [FILL_W-1:0]        thr;
  status_t                  res_status;
  logic [IDX_W-1:0]         res_slot;
  logic [PAYLOAD_WIDTH-1:0] res_pay;
  logic [COUNT_W-1:0]       res_count;

  lph_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign thr  = (fill_r >= FILL_W'(1)) ? fill_r - FILL_W'(1) : '0;
  assign full = (count_r >= COUNT_W'(thr)) || (count_r >= COUNT_W'(SLOTS));
  assign hit  = rsp.valid && (rsp.hash == hash_r);

  always_comb begin
    done       = 1'b0;
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    res_pay    = '0;
    res_count  = count_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          done       = 1'b1;
          res_status = ST_FULL;
        end else if (!rsp.valid) begin
          done       = 1'b1;
          res_status = ST_INSERTED;
          res_slot   = idx_r;
          res_count  = count_r + COUNT_W'(1);
        end
      end
      CMD_LOOKUP: begin
        if (!rsp.valid) begin
          done = 1'b1;
        end else if (hit) begin
          done       = 1'b1;
          res_status = ST_FOUND;
          res_slot   = idx_r;
          res_pay    = rsp.payload;
        end else if (probe_n_r == IDX_W'(SLOTS - 1)) begin
          done = 1'b1;
        end
      end
      CMD_CLEAR: begin
        done       = 1'b1;
        res_status = ST_CLEARED;
        res_count  = '0;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign fin = (state_r == S_PROBE) && done && out_free;

  always_comb begin
    if (accept) begin
      req.rd_addr = in_ch.key_hash[IDX_W-1:0];
    end else if (state_r == S_PROBE && !done) begin
      req.rd_addr = idx_r + IDX_W'(1);
    end else begin
      req.rd_addr = idx_r;
    end
    req.wr_en      = fin && (res_status == ST_INSERTED);
    req.wr_addr    = idx_r;
    req.wr_hash    = hash_r;
    req.wr_payload = pay_r;
    req.clear      = fin && (cmd_r == CMD_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmd_r        <= '0;
      hash_r       <= '0;
      pay_r        <= '0;
      idx_r        <= '0;
      probe_n_r    <= '0;
      count_r      <= '0;
      fill_r       <= FILL_RESET;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_NOT_FOUND;
      out_slot_r   <= '0;
      out_pay_r    <= '0;
    end else begin
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= in_ch.command;
            hash_r    <= in_ch.key_hash;
            pay_r     <= in_ch.payload_in;
            idx_r     <= in_ch.key_hash[IDX_W-1:0];
            probe_n_r <= '0;
            state_r   <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (fin) begin
            out_status_r <= res_status;
            out_slot_r   <= res_slot;
            out_pay_r    <= res_pay;
            count_r      <= res_count;
            state_r      <= S_IDLE;
          end else if (!done) begin
            idx_r     <= idx_r + IDX_W'(1);
            probe_n_r <= probe_n_r + IDX_W'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.slot_index      = out_slot_r;
  assign out_ch.payload_out     = out_pay_r;
  assign out_ch.entry_count_out = count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(SLOTS))
    else $error("entry count above slot count");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && res_status == ST_INSERTED) |=> (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("insert did not bump the entry count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && res_status == ST_FULL) |=> $stable(count_r))
    else $error("refused insert changed the entry count");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && done && !out_free) |=> (state_r == S_PROBE))
    else $error("finished probe left before its result was stored");
`endif

endmodule

`default_nettype wire
